>>> src/ppl_pkg.sv
// Shared types and constants for the patchy pair potential lookup.
`timescale 1ns / 1ps

package ppl_pkg;

    localparam int SITE_W      = 48;
    localparam int WORD_W      = 32;
    localparam int ENERGY_W    = 36;
    localparam int INV_STEP_W  = 24;
    localparam int SCALE_SHIFT = 24;
    localparam int FRAC_SHIFT  = 16;
    localparam int LANES       = 9;
    localparam int TAB_COUNT   = 7;
    localparam int SITES       = 3;

    localparam logic [INV_STEP_W-1:0] INV_STEP_RESET = 24'd65536;

    localparam logic [2:0] TAB_BB   = 3'd0;
    localparam logic [2:0] TAB_HS   = 3'd1;
    localparam logic [2:0] TAB_BS1  = 3'd2;
    localparam logic [2:0] TAB_BS2  = 3'd3;
    localparam logic [2:0] TAB_S1S1 = 3'd4;
    localparam logic [2:0] TAB_S1S2 = 3'd5;
    localparam logic [2:0] TAB_S2S2 = 3'd6;

    localparam logic [1:0] KIND_M = 2'd0;
    localparam logic [1:0] KIND_C = 2'd1;

    localparam logic [1:0] CFG_RANGE_SQUARED  = 2'd0;
    localparam logic [1:0] CFG_INV_STEP       = 2'd1;
    localparam logic [1:0] CFG_MIXTURE_ENABLE = 2'd2;

    // Lane 0 is the center pair; lanes 1 to 8 are the other site pairs.
    localparam int LANE_FIRST  [LANES] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    localparam int LANE_SECOND [LANES] = '{0, 1, 2, 0, 1, 2, 0, 1, 2};

    // Lanes that drive the two read ports of each table.
    localparam int TAB_LANE_A [TAB_COUNT] = '{0, 0, 1, 2, 4, 5, 8};
    localparam int TAB_LANE_B [TAB_COUNT] = '{0, 0, 3, 6, 4, 7, 8};

    typedef struct packed {
        logic               mode;
        logic [47:0]        first_center;
        logic [47:0]        first_patch_one;
        logic [47:0]        first_patch_two;
        logic [47:0]        second_center;
        logic [47:0]        second_patch_one;
        logic [47:0]        second_patch_two;
        logic [1:0]         first_kind;
        logic [1:0]         second_kind;
        logic [2:0]         table_select;
        logic [9:0]         table_index;
        logic signed [31:0] table_word;
    } item_t;

    typedef struct packed {
        logic signed [35:0] energy;
        logic               bonded;
        logic               kind_error;
    } result_t;

    // Control that travels alongside an item through the pipeline.
    typedef struct packed {
        logic               valid;
        logic               mode;
        logic               negate;
        logic               kind_err;
        logic [2:0]         sel;
        logic [9:0]         idx;
        logic signed [31:0] word;
    } side_t;

endpackage

>>> src/patchy_pair_potential_lookup.sv
// Top level of the patchy pair potential lookup pipeline.
`timescale 1ns / 1ps

//  Channel   Signals                            Transfer
//  --------  ---------------------------------  ----------------------------------
//  item in   start, busy, item                  taken when start is high, busy low
//  result    done, result                       shown for one cycle while done high
//  config    cfg_we, cfg_index, cfg_data        written when cfg_we is high
//
// One item enters every cycle; busy never rises. Each result passes through
// three distance stages, one stage per root bit in the square root, two scaling
// stages, the table read and two summing stages. Table writes take effect at
// the read stage, so every item sees the writes of the items before it.
// Reset clears the pipeline valid bits and the configuration and result
// registers; the data registers and tables are not cleared.

module patchy_pair_potential_lookup #(
    parameter int TABLE_DEPTH = 1024,
    parameter int COORD_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ppl_pkg::item_t      item,
    output logic                done,
    output ppl_pkg::result_t    result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int N       = COORD_BITS + ppl_pkg::FRAC_SHIFT / 2;
    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int SB_LEN  = N + 5;
    localparam int RNG_LEN = N + 3;
    localparam int LANES   = ppl_pkg::LANES;
    localparam int PROD_W  = N + ppl_pkg::INV_STEP_W;
    localparam logic [N-1:0] MAX_IDX = N'(TABLE_DEPTH - 1);

    // Configuration registers.
    logic [31:0]                     range_squared_reg;
    logic [ppl_pkg::INV_STEP_W-1:0]  inv_step_reg;
    logic                            mixture_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_squared_reg  <= '0;
            inv_step_reg       <= ppl_pkg::INV_STEP_RESET;
            mixture_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppl_pkg::CFG_RANGE_SQUARED:  range_squared_reg  <= cfg_data;
                ppl_pkg::CFG_INV_STEP:       inv_step_reg       <= cfg_data[23:0];
                ppl_pkg::CFG_MIXTURE_ENABLE: mixture_enable_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Item entry: kinds are checked here, and the sign rule is settled.
    ppl_pkg::side_t side_next;
    logic           kind_bad;

    always_comb
    begin
        kind_bad = (item.first_kind > ppl_pkg::KIND_C) ||
                   (item.second_kind > ppl_pkg::KIND_C);
        side_next.valid    = start;
        side_next.mode     = item.mode;
        side_next.kind_err = mixture_enable_reg && !item.mode && kind_bad;
        side_next.negate   = mixture_enable_reg && !item.mode && !kind_bad &&
                             (item.first_kind != item.second_kind);
        side_next.sel      = item.table_select;
        side_next.idx      = item.table_index;
        side_next.word     = item.table_word;
    end

    ppl_pkg::side_t side_reg [SB_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SB_LEN; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < SB_LEN; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Nine site pairs: distance, square root and scaling to a table bin.
    logic [47:0]             first_sites  [ppl_pkg::SITES];
    logic [47:0]             second_sites [ppl_pkg::SITES];
    logic [2*COORD_BITS-1:0] d2_w      [LANES];
    logic [LANES-1:0]        in_range_w;
    logic [N-1:0]            root_w    [LANES];
    logic [PROD_W-1:0]       prod_reg  [LANES];
    logic [AW-1:0]           idx_reg   [LANES];

    assign first_sites[0]  = item.first_center;
    assign first_sites[1]  = item.first_patch_one;
    assign first_sites[2]  = item.first_patch_two;
    assign second_sites[0] = item.second_center;
    assign second_sites[1] = item.second_patch_one;
    assign second_sites[2] = item.second_patch_two;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [N-1:0] idx_full;

        ppl_dist #(
            .COORD_BITS (COORD_BITS)
        ) u_dist (
            .clk           (clk),
            .site_a        (first_sites[ppl_pkg::LANE_FIRST[l]]),
            .site_b        (second_sites[ppl_pkg::LANE_SECOND[l]]),
            .range_squared (range_squared_reg),
            .d2            (d2_w[l]),
            .in_range      (in_range_w[l])
        );

        ppl_sqrt #(
            .COORD_BITS (COORD_BITS)
        ) u_sqrt (
            .clk  (clk),
            .d2   (d2_w[l]),
            .root (root_w[l])
        );

        assign idx_full = prod_reg[l][PROD_W-1:ppl_pkg::SCALE_SHIFT];

        always_ff @(posedge clk)
        begin
            prod_reg[l] <= PROD_W'(root_w[l]) * PROD_W'(inv_step_reg);
            idx_reg[l]  <= (idx_full > MAX_IDX) ? AW'(TABLE_DEPTH - 1) : AW'(idx_full);
        end
    end

    // Range flags wait beside the root, scaling and table read stages.
    logic [LANES-1:0] rng_reg [RNG_LEN];

    always_ff @(posedge clk)
    begin
        rng_reg[0] <= in_range_w;
        for (int i = 1; i < RNG_LEN; i++)
        begin
            rng_reg[i] <= rng_reg[i-1];
        end
    end

    // Table stage: writes land at the same stage as the lookups.
    ppl_pkg::side_t     wr_side;
    logic               wr_idx_ok;
    logic [ppl_pkg::TAB_COUNT-1:0] tab_we;
    logic signed [31:0] rd_a [ppl_pkg::TAB_COUNT];
    logic signed [31:0] rd_b [ppl_pkg::TAB_COUNT];

    assign wr_side   = side_reg[SB_LEN-1];
    assign wr_idx_ok = 32'(wr_side.idx) < 32'(TABLE_DEPTH);

    for (genvar t = 0; t < ppl_pkg::TAB_COUNT; t++)
    begin : g_tab
        assign tab_we[t] = wr_side.valid && wr_side.mode && wr_idx_ok &&
                           (wr_side.sel == 3'(t));

        ppl_table_mem #(
            .DEPTH (TABLE_DEPTH),
            .AW    (AW)
        ) u_mem (
            .clk       (clk),
            .we        (tab_we[t]),
            .wr_addr   (AW'(wr_side.idx)),
            .wr_data   (wr_side.word),
            .rd_addr_a (idx_reg[ppl_pkg::TAB_LANE_A[t]]),
            .rd_addr_b (idx_reg[ppl_pkg::TAB_LANE_B[t]]),
            .rd_data_a (rd_a[t]),
            .rd_data_b (rd_b[t])
        );
    end

    ppl_pkg::side_t side6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side6_reg <= '0;
        end
        else
        begin
            side6_reg <= wr_side;
        end
    end

    // First summing stage: signed, range-gated terms into three partial sums.
    // The hard-sphere table never takes the mixture sign.
    logic signed [32:0] term [LANES + 1];
    logic signed [31:0] raw  [LANES + 1];
    logic [LANES:0]     term_on;
    logic [LANES:0]     term_neg;
    logic signed [35:0] part_reg [3];
    logic [LANES-1:0]   rng_last;

    assign rng_last = rng_reg[RNG_LEN-1];

    assign raw[0] = rd_a[ppl_pkg::TAB_BB];
    assign raw[1] = rd_a[ppl_pkg::TAB_BS1];
    assign raw[2] = rd_a[ppl_pkg::TAB_BS2];
    assign raw[3] = rd_b[ppl_pkg::TAB_BS1];
    assign raw[4] = rd_a[ppl_pkg::TAB_S1S1];
    assign raw[5] = rd_a[ppl_pkg::TAB_S1S2];
    assign raw[6] = rd_b[ppl_pkg::TAB_BS2];
    assign raw[7] = rd_b[ppl_pkg::TAB_S1S2];
    assign raw[8] = rd_a[ppl_pkg::TAB_S2S2];
    assign raw[9] = rd_a[ppl_pkg::TAB_HS];

    assign term_on  = {rng_last[0], rng_last};
    assign term_neg = {1'b0, {LANES{side6_reg.negate}}};

    always_comb
    begin
        for (int i = 0; i <= LANES; i++)
        begin
            if (!term_on[i])
            begin
                term[i] = '0;
            end
            else if (term_neg[i])
            begin
                term[i] = -33'(raw[i]);
            end
            else
            begin
                term[i] = 33'(raw[i]);
            end
        end
    end

    ppl_pkg::side_t side7_reg;
    logic           center_ok7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side7_reg <= '0;
        end
        else
        begin
            side7_reg <= side6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg[0]    <= 36'(term[0]) + 36'(term[9]) + 36'(term[1]) + 36'(term[2]);
        part_reg[1]    <= 36'(term[3]) + 36'(term[4]) + 36'(term[5]);
        part_reg[2]    <= 36'(term[6]) + 36'(term[7]) + 36'(term[8]);
        center_ok7_reg <= rng_last[0];
    end

    // Final stage: total, zeroed for writes, bad kinds and centers out of range.
    logic signed [35:0] energy_next;
    logic               done_reg;
    ppl_pkg::result_t   result_reg;

    assign energy_next = (center_ok7_reg && !side7_reg.mode && !side7_reg.kind_err)
                         ? (part_reg[0] + part_reg[1] + part_reg[2]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg              <= side7_reg.valid;
            result_reg.energy     <= energy_next;
            result_reg.bonded     <= energy_next[35];
            result_reg.kind_error <= side7_reg.kind_err;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_write_only_in_write_mode: assert property (
        @(posedge clk) disable iff (!rst_n)
        (tab_we != '0) |-> (wr_side.valid && wr_side.mode)
    ) else $error("table written without a write-mode item at the read stage");

    a_kind_error_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.kind_error) |-> (result.energy == '0 && !result.bonded)
    ) else $error("kind error result carries energy");

    a_single_table_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        $onehot0(tab_we)
    ) else $error("more than one table written in a cycle");
`endif

endmodule

>>> src/ppl_dist.sv
// Minimum-image squared distance between two sites, three register stages.
`timescale 1ns / 1ps

module ppl_dist #(
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic [47:0]               site_a,
    input  logic [47:0]               site_b,
    input  logic [31:0]               range_squared,
    output logic [2*COORD_BITS-1:0]   d2,
    output logic                      in_range
);

    localparam int C     = COORD_BITS;
    localparam int EXT_W = (3 * C > ppl_pkg::SITE_W) ? 3 * C : ppl_pkg::SITE_W;
    localparam int CMP_W = (2 * C > 32) ? 2 * C : 32;

    logic [EXT_W-1:0] ext_a;
    logic [EXT_W-1:0] ext_b;
    logic [C-1:0]     mag_next [3];
    logic [C-1:0]     mag_reg  [3];
    logic [2*C-1:0]   sq_reg   [3];
    logic [2*C-1:0]   d2_next;
    logic [2*C-1:0]   d2_reg;
    logic             in_range_reg;

    // Coordinates above the 48 input bits read as zero.
    assign ext_a = EXT_W'(site_a);
    assign ext_b = EXT_W'(site_b);

    always_comb
    begin
        logic [C-1:0] diff;
        for (int ax = 0; ax < 3; ax++)
        begin
            diff = ext_a[ax*C +: C] - ext_b[ax*C +: C];
            mag_next[ax] = diff[C-1] ? (C'(0) - diff) : diff;
        end
    end

    assign d2_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk)
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            mag_reg[ax] <= mag_next[ax];
            sq_reg[ax]  <= mag_reg[ax] * mag_reg[ax];
        end
        d2_reg       <= d2_next;
        in_range_reg <= CMP_W'(d2_next) < CMP_W'(range_squared);
    end

    assign d2       = d2_reg;
    assign in_range = in_range_reg;

endmodule

>>> src/ppl_sqrt.sv
// Pipelined integer square root of d2 scaled by 2^16, one root bit per stage.
`timescale 1ns / 1ps

module ppl_sqrt #(
    parameter int COORD_BITS = 16
) (
    input  logic                                        clk,
    input  logic [2*COORD_BITS-1:0]                     d2,
    output logic [COORD_BITS+ppl_pkg::FRAC_SHIFT/2-1:0] root
);

    localparam int N     = COORD_BITS + ppl_pkg::FRAC_SHIFT / 2;
    localparam int REM_W = N + 2;
    localparam int RAD_W = 2 * N;

    logic [REM_W-1:0] rem_in   [N];
    logic [N-1:0]     root_in  [N];
    logic [RAD_W-1:0] rad_in   [N];
    logic [REM_W-1:0] rem_reg  [N];
    logic [N-1:0]     root_reg [N];
    logic [RAD_W-1:0] rad_reg  [N];

    assign rem_in[0]  = '0;
    assign root_in[0] = '0;
    assign rad_in[0]  = {d2, {ppl_pkg::FRAC_SHIFT{1'b0}}};

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [REM_W-1:0] rem_next;
        logic [N-1:0]     root_next;

        if (k > 0)
        begin : g_link
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
            assign rad_in[k]  = rad_reg[k-1];
        end

        // Bring down two radicand bits and try to append a one to the root.
        always_comb
        begin
            logic [REM_W-1:0] r2;
            logic [REM_W-1:0] trial;
            r2    = {rem_in[k][REM_W-3:0], rad_in[k][RAD_W-1 -: 2]};
            trial = {root_in[k], 2'b01};
            if (r2 >= trial)
            begin
                rem_next  = r2 - trial;
                root_next = {root_in[k][N-2:0], 1'b1};
            end
            else
            begin
                rem_next  = r2;
                root_next = {root_in[k][N-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            rad_reg[k]  <= rad_in[k] << 2;
        end
    end

    assign root = root_reg[N-1];

endmodule

>>> src/ppl_table_mem.sv
// One energy table: one write port and two registered read ports.
`timescale 1ns / 1ps

module ppl_table_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [31:0]   wr_data,
    input  logic [AW-1:0]        rd_addr_a,
    input  logic [AW-1:0]        rd_addr_b,
    output logic signed [31:0]   rd_data_a,
    output logic signed [31:0]   rd_data_b
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_a_reg;
    logic signed [31:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule
